>>> design/snils_pkg.sv
// ----------------------------------------------------------------------------
// snils_pkg
// Types, character codes and constants shared by the number check logic.
// ----------------------------------------------------------------------------
package snils_pkg;

  typedef logic [7:0] char_t;
  typedef logic [3:0] digit_t;
  typedef logic [3:0] count_t;
  typedef logic [1:0] run_t;
  typedef logic [8:0] sum_t;
  typedef logic [6:0] code_t;

  localparam char_t  CHAR_ZERO  = 8'h30;
  localparam char_t  CHAR_NINE  = 8'h39;
  localparam char_t  CHAR_SPACE = 8'h20;
  localparam char_t  CHAR_DASH  = 8'h2d;

  localparam count_t PREFIX_DIGITS = 4'd9;
  localparam count_t TOTAL_DIGITS  = 4'd11;
  localparam count_t COUNT_CAP     = 4'd12;
  localparam run_t   RUN_LIMIT     = 2'd3;
  localparam code_t  CODE_SCALE    = 7'd10;
  localparam sum_t   MODULUS       = 9'd101;
  localparam code_t  MAPPED_ZERO   = 7'd100;

  // sum is at most 511, so three conditional subtractions reduce it
  function automatic code_t mod_reduce(input sum_t s);
    sum_t k;
    k = s;
    if (k >= 9'(4 * MODULUS)) begin
      k = k - 9'(4 * MODULUS);
    end
    if (k >= 9'(2 * MODULUS)) begin
      k = k - 9'(2 * MODULUS);
    end
    if (k >= MODULUS) begin
      k = k - MODULUS;
    end
    if (k[6:0] == MAPPED_ZERO) begin
      return '0;
    end
    return k[6:0];
  endfunction

endpackage

>>> design/snils_in_if.sv
// ----------------------------------------------------------------------------
// snils_in_if
// Character channel: one character byte and a last-character flag per
// transaction.
// ----------------------------------------------------------------------------
interface snils_in_if;
  logic                 valid;
  logic                 ready;
  snils_pkg::char_t     char_code;
  logic                 last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

>>> design/snils_out_if.sv
// ----------------------------------------------------------------------------
// snils_out_if
// Result channel: one verdict bit per transaction.
// ----------------------------------------------------------------------------
interface snils_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

>>> design/snils_check_digit_validator.sv
// ----------------------------------------------------------------------------
// snils_check_digit_validator
// Streams a number string one character per transaction and checks its
// two-digit control code against the weighted sum of the first nine digits.
// A last character's verdict is registered as it leaves the input register.
// Throughput: 1 character per cycle; a last one waits on a held verdict.
// Reset (synchronous, rst_n low): empty pipeline, string state cleared.
// After each last character the string state returns to its reset value.
// ----------------------------------------------------------------------------
module snils_check_digit_validator (
  input  logic         clk,
  input  logic         rst_n,
  snils_in_if.sink     in_ch,
  snils_out_if.source  out_ch
);

  // input register
  logic                s1_valid_r;
  snils_pkg::char_t    s1_char_r;
  logic                s1_last_r;

  // string state
  logic                bad_r, bad_nxt;
  snils_pkg::count_t   cnt_r, cnt_nxt;
  snils_pkg::run_t     run_r, run_nxt;
  snils_pkg::digit_t   prev_r, prev_nxt;
  snils_pkg::sum_t     sum_r, sum_nxt;
  snils_pkg::code_t    code_r, code_nxt;
  logic                zero_r, zero_nxt;

  // result register
  logic                out_valid_r;
  logic                out_res_r;

  logic                out_free;
  logic                s1_fire;
  logic                is_digit;
  logic                is_skip;
  snils_pkg::digit_t   digit;
  snils_pkg::digit_t   weight;
  logic                verdict;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready = !s1_valid_r || s1_fire;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.valid_res = out_res_r;

  always_comb begin
    is_digit = s1_char_r inside {[snils_pkg::CHAR_ZERO:snils_pkg::CHAR_NINE]};
    is_skip  = s1_char_r inside {snils_pkg::CHAR_SPACE, snils_pkg::CHAR_DASH};
    digit    = 4'(s1_char_r - snils_pkg::CHAR_ZERO);
    weight   = 4'(snils_pkg::PREFIX_DIGITS - cnt_r);
    bad_nxt  = bad_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    prev_nxt = prev_r;
    sum_nxt  = sum_r;
    code_nxt = code_r;
    zero_nxt = zero_r;
    if (is_digit) begin
      if (cnt_r < snils_pkg::PREFIX_DIGITS) begin
        if (cnt_r != '0 && digit == prev_r) begin
          if (run_r < snils_pkg::RUN_LIMIT) begin
            run_nxt = run_r + 2'd1;
          end
          if (run_nxt >= snils_pkg::RUN_LIMIT) begin
            bad_nxt = 1'b1;
          end
        end else begin
          run_nxt = 2'd1;
        end
        prev_nxt = digit;
        sum_nxt  = sum_r + 9'(digit * weight);
        if (digit != '0) begin
          zero_nxt = 1'b0;
        end
      end else if (cnt_r == snils_pkg::PREFIX_DIGITS) begin
        code_nxt = 7'(digit * snils_pkg::CODE_SCALE);
      end else if (cnt_r == snils_pkg::PREFIX_DIGITS + 4'd1) begin
        code_nxt = code_r + 7'(digit);
      end
      if (cnt_r < snils_pkg::COUNT_CAP) begin
        cnt_nxt = cnt_r + 4'd1;
      end
    end else if (!is_skip) begin
      bad_nxt = 1'b1;
    end
    verdict = !bad_nxt && (cnt_nxt == snils_pkg::TOTAL_DIGITS) && !zero_nxt &&
              (code_nxt == snils_pkg::mod_reduce(sum_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char_r <= in_ch.char_code;
      s1_last_r <= in_ch.last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      bad_r  <= 1'b0;
      cnt_r  <= '0;
      run_r  <= '0;
      prev_r <= '0;
      sum_r  <= '0;
      code_r <= '0;
      zero_r <= 1'b1;
    end else if (s1_fire) begin
      bad_r  <= bad_nxt;
      cnt_r  <= cnt_nxt;
      run_r  <= run_nxt;
      prev_r <= prev_nxt;
      sum_r  <= sum_nxt;
      code_r <= code_nxt;
      zero_r <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r && s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r && s1_last_r) begin
      out_res_r <= verdict;
    end
  end

  a_out_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("result appeared without a last character");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (cnt_r == '0 && zero_r && !bad_r && sum_r == '0))
    else $error("string state not cleared after last character");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= snils_pkg::COUNT_CAP)
    else $error("digit count above cap");

endmodule

>>> verif/snils_verdict_checker.sv
// ----------------------------------------------------------------------------
// snils_verdict_checker
// Watches the character and verdict channels of the number check block.
// Every accepted character updates a local copy of the string state. A final
// character queues the expected verdict. Each accepted verdict is compared
// with the oldest queued one. Mismatches and unexpected verdicts are counted
// for the testbench top.
// ----------------------------------------------------------------------------
module snils_verdict_checker (
  input  logic  clk,
  input  logic  rst_n,
  snils_in_if   in_ch,
  snils_out_if  out_ch,
  output int    fail_count,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic              str_bad;
  snils_pkg::count_t n_digits;
  snils_pkg::run_t   run_len;
  snils_pkg::digit_t last_digit;
  snils_pkg::sum_t   prefix_sum;
  snils_pkg::code_t  ctrl_code;
  logic              zeros_only;
  bit                verdicts_q[$];

  task automatic clear_string();
    str_bad    = 1'b0;
    n_digits   = '0;
    run_len    = '0;
    last_digit = '0;
    prefix_sum = '0;
    ctrl_code  = '0;
    zeros_only = 1'b1;
  endtask

  function automatic bit snils_verdict();
    int rem;
    rem = int'(prefix_sum) % int'(snils_pkg::MODULUS);
    if (rem == int'(snils_pkg::MAPPED_ZERO)) begin
      rem = 0;
    end
    return !str_bad && (n_digits == snils_pkg::TOTAL_DIGITS) && !zeros_only &&
           (int'(ctrl_code) == rem);
  endfunction

  task automatic absorb_char(input snils_pkg::char_t c, input logic is_last);
    snils_pkg::digit_t d;
    if (c >= snils_pkg::CHAR_ZERO && c <= snils_pkg::CHAR_NINE) begin
      d = snils_pkg::digit_t'(c - snils_pkg::CHAR_ZERO);
      if (n_digits < snils_pkg::PREFIX_DIGITS) begin
        if (n_digits != 0 && d == last_digit) begin
          if (run_len < snils_pkg::RUN_LIMIT) begin
            run_len = run_len + 1'b1;
          end
          if (run_len >= snils_pkg::RUN_LIMIT) begin
            str_bad = 1'b1;
          end
        end else begin
          run_len = 2'd1;
        end
        last_digit = d;
        prefix_sum = snils_pkg::sum_t'(int'(prefix_sum) +
                     int'(d) * (int'(snils_pkg::PREFIX_DIGITS) - int'(n_digits)));
        if (d != 0) begin
          zeros_only = 1'b0;
        end
      end else if (n_digits == snils_pkg::PREFIX_DIGITS) begin
        ctrl_code = snils_pkg::code_t'(int'(d) * int'(snils_pkg::CODE_SCALE));
      end else if (n_digits == snils_pkg::PREFIX_DIGITS + 1) begin
        ctrl_code = snils_pkg::code_t'(int'(ctrl_code) + int'(d));
      end
      if (n_digits < snils_pkg::COUNT_CAP) begin
        n_digits = n_digits + 1'b1;
      end
    end else if (c != snils_pkg::CHAR_SPACE && c != snils_pkg::CHAR_DASH) begin
      str_bad = 1'b1;
    end
    if (is_last) begin
      verdicts_q.insert(verdicts_q.size(), snils_verdict());
      clear_string();
    end
  endtask

  always @(posedge clk) begin
    bit want;
    if (!rst_n) begin
      clear_string();
      verdicts_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (verdicts_q.size() == 0) begin
          $error("valid_res: no transaction expected, actual %0b", out_ch.valid_res);
          fail_count++;
        end else begin
          want = verdicts_q.pop_front();
          if (out_ch.valid_res !== want) begin
            $error("valid_res mismatch: expected %0b, actual %0b", want, out_ch.valid_res);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        absorb_char(in_ch.char_code, in_ch.last_char);
      end
    end
    pending = verdicts_q.size();
  end

endmodule

>>> verif/snils_check_digit_validator_tb.sv
// ----------------------------------------------------------------------------
// snils_check_digit_validator_tb
// Drives number strings into the check block one character per transaction
// and lets the verdict checker compare every verdict. A short directed set
// comes first, then random well-formed numbers in several layouts, numbers
// broken in one way each, and raw byte noise. Both sides stall at random,
// the receiver once holds off long enough to back up the block, and the
// last part runs without idling.
// ----------------------------------------------------------------------------
module snils_check_digit_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum int {
    K_VALID, K_BAD_CODE, K_RUN3, K_BAD_CHAR, K_COUNT_OFF, K_ZERO_PREFIX, K_NOISE
  } str_kind_t;

  typedef enum int {FMT_PLAIN, FMT_GROUPED, FMT_LOOSE} fmt_t;

  logic  clk = 1'b0;
  logic  rst_n;
  int    fail_count;
  int    pending;
  int    chars_sent = 0;
  int    idle_cycles = 0;
  bit    tx_idle_en = 1'b0;
  bit    rx_idle_en = 1'b0;
  bit    hold_req = 1'b0;
  snils_pkg::char_t str_q[$];

  snils_in_if  in_if ();
  snils_out_if out_if ();

  snils_check_digit_validator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  snils_verdict_checker verdict_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  task automatic add_char(input snils_pkg::char_t c);
    str_q.insert(str_q.size(), c);
  endtask

  task automatic put_char(input snils_pkg::char_t c, input logic is_last);
    int gap;
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.last_char <= is_last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_string();
    foreach (str_q[i]) begin
      put_char(str_q[i], i == str_q.size() - 1);
    end
  endtask

  task automatic send_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) begin
      add_char(snils_pkg::char_t'(s[i]));
    end
    send_string();
  endtask

  task automatic make_string();
    str_kind_t         kind;
    snils_pkg::digit_t num[11];
    snils_pkg::digit_t dq[$];
    fmt_t              fmt;
    snils_pkg::char_t  b;
    int                r, s, pos, n;
    r = $urandom_range(0, 99);
    if (r < 55)      kind = K_VALID;
    else if (r < 65) kind = K_BAD_CODE;
    else if (r < 73) kind = K_RUN3;
    else if (r < 80) kind = K_BAD_CHAR;
    else if (r < 87) kind = K_COUNT_OFF;
    else if (r < 90) kind = K_ZERO_PREFIX;
    else             kind = K_NOISE;
    str_q.delete();
    if (kind == K_NOISE) begin
      n = $urandom_range(1, 14);
      repeat (n) begin
        case ($urandom_range(0, 3))
          0: begin
            add_char(snils_pkg::char_t'($urandom_range(0, 255)));
          end
          1: begin
            add_char($urandom_range(0, 1) ? snils_pkg::CHAR_SPACE : snils_pkg::CHAR_DASH);
          end
          default: begin
            add_char(snils_pkg::char_t'(snils_pkg::CHAR_ZERO + $urandom_range(0, 9)));
          end
        endcase
      end
    end else begin
      // prefix without three equal digits in a row
      for (int i = 0; i < 9; i++) begin
        num[i] = snils_pkg::digit_t'($urandom_range(0, 9));
        while (i >= 2 && num[i] == num[i-1] && num[i] == num[i-2]) begin
          num[i] = snils_pkg::digit_t'($urandom_range(0, 9));
        end
      end
      if (kind == K_RUN3) begin
        pos = $urandom_range(0, 6);
        num[pos+1] = num[pos];
        num[pos+2] = num[pos];
      end else if (kind == K_ZERO_PREFIX) begin
        for (int i = 0; i < 9; i++) num[i] = '0;
      end
      s = 0;
      for (int i = 0; i < 9; i++) begin
        s += int'(num[i]) * (int'(snils_pkg::PREFIX_DIGITS) - i);
      end
      s = s % int'(snils_pkg::MODULUS);
      if (s == int'(snils_pkg::MAPPED_ZERO)) s = 0;
      if (kind == K_BAD_CODE) s = (s + $urandom_range(1, 99)) % 100;
      num[9]  = snils_pkg::digit_t'(s / 10);
      num[10] = snils_pkg::digit_t'(s % 10);
      foreach (num[i]) dq.insert(dq.size(), num[i]);
      if (kind == K_COUNT_OFF) begin
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 1)) begin
          repeat (n) dq.insert(dq.size(), snils_pkg::digit_t'($urandom_range(0, 9)));
        end else begin
          repeat (n) dq.delete($urandom_range(0, dq.size() - 1));
        end
      end
      fmt = fmt_t'($urandom_range(0, 2));
      foreach (dq[i]) begin
        if (fmt == FMT_GROUPED && (i == 3 || i == 6)) add_char(snils_pkg::CHAR_DASH);
        if (fmt == FMT_GROUPED && i == 9) add_char(snils_pkg::CHAR_SPACE);
        if (fmt == FMT_LOOSE) begin
          while ($urandom_range(0, 5) == 0) begin
            add_char($urandom_range(0, 1) ? snils_pkg::CHAR_SPACE : snils_pkg::CHAR_DASH);
          end
        end
        add_char(snils_pkg::char_t'(snils_pkg::CHAR_ZERO + dq[i]));
      end
      if (fmt == FMT_LOOSE && $urandom_range(0, 3) == 0) begin
        add_char($urandom_range(0, 1) ? snils_pkg::CHAR_SPACE : snils_pkg::CHAR_DASH);
      end
      if (kind == K_BAD_CHAR) begin
        do b = snils_pkg::char_t'($urandom_range(0, 255));
        while ((b >= snils_pkg::CHAR_ZERO && b <= snils_pkg::CHAR_NINE) ||
               b == snils_pkg::CHAR_SPACE || b == snils_pkg::CHAR_DASH);
        str_q.insert($urandom_range(0, str_q.size()), b);
      end
    end
  endtask

  // receiver: random stall bursts and one long hold-off
  initial begin
    int hold_left;
    int stall_left;
    bit hold_done;
    hold_left = 0;
    stall_left = 0;
    hold_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 5) == 0) begin
          stall_left = $urandom_range(1, 9);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("snils_check_digit_validator_tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.char_code = '0;
    in_if.last_char = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // weighted sum 100 maps to code 00
    send_text("12345100100");
    send_text("7");
    put_char(snils_pkg::CHAR_SPACE, 1'b1);
    put_char(snils_pkg::CHAR_DASH, 1'b1);
    put_char(8'hff, 1'b1);
    put_char(8'h00, 1'b1);
    send_text("00000000000");

    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    while (chars_sent < 800) begin
      make_string();
      send_string();
    end

    // back up the block behind a stalled receiver
    tx_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (40) put_char(snils_pkg::char_t'(snils_pkg::CHAR_ZERO + $urandom_range(0, 9)), 1'b1);
    in_if.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);

    tx_idle_en = 1'b1;
    while (chars_sent < 1500) begin
      make_string();
      send_string();
    end

    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    while (chars_sent < 1900) begin
      make_string();
      send_string();
    end
    in_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("snils_check_digit_validator_tb passed");
    end else begin
      $display("snils_check_digit_validator_tb failed");
    end
    $finish;
  end

endmodule
